[hw/rtl/stunbr_pkg.sv]
package stunbr_pkg;

	localparam int MAX_PACKET_BYTES = 512;
	localparam int HEADER_BYTES = 20;
	// offset counter saturates at MAX_PACKET_BYTES
	localparam int OFS_W = $clog2(MAX_PACKET_BYTES + 1);
	// attribute byte index never exceeds the packet byte count
	localparam int IDX_W = OFS_W;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_BIND_CODE = 2'd0;
	localparam logic [1:0] REG_MAPPED_CODE = 2'd1;
	localparam logic [1:0] REG_CHANGED_CODE = 2'd2;
	localparam logic [1:0] REG_IPV4_CODE = 2'd3;

	localparam logic [15:0] RST_BIND_CODE = 16'd257;
	localparam logic [15:0] RST_MAPPED_CODE = 16'd1;
	localparam logic [15:0] RST_CHANGED_CODE = 16'd5;
	localparam logic [7:0] RST_IPV4_CODE = 8'd1;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_ATTR_HDR = 3'd1;
	localparam logic [2:0] PH_VALUE = 3'd2;
	localparam logic [2:0] PH_PAD = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;
	localparam logic [2:0] PH_HALT = 3'd5;

	localparam logic [1:0] SLOT_NONE = 2'd0;
	localparam logic [1:0] SLOT_MAPPED = 2'd1;
	localparam logic [1:0] SLOT_CHANGED = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOT_BINDING = 3'd1;
	localparam logic [2:0] ST_OVERRUN = 3'd2;
	localparam logic [2:0] ST_BAD_ADDR = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;

	localparam logic [15:0] ADDR_LEN_SHORT = 16'd8;
	localparam logic [15:0] ADDR_LEN_LONG = 16'd20;

	typedef struct packed {
		logic [15:0] bind_code;
		logic [15:0] mapped_code;
		logic [15:0] changed_code;
		logic [7:0]  ipv4_code;
	} cfg_t;

endpackage

[hw/rtl/stunbr_cfg.sv]
module stunbr_cfg
	import stunbr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic [1:0] reg_sel;

	assign reg_sel = paddr[3:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bind_code <= RST_BIND_CODE;
			cfg_q.mapped_code <= RST_MAPPED_CODE;
			cfg_q.changed_code <= RST_CHANGED_CODE;
			cfg_q.ipv4_code <= RST_IPV4_CODE;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_BIND_CODE: cfg_q.bind_code <= pwdata[15:0];
				REG_MAPPED_CODE: cfg_q.mapped_code <= pwdata[15:0];
				REG_CHANGED_CODE: cfg_q.changed_code <= pwdata[15:0];
				REG_IPV4_CODE: cfg_q.ipv4_code <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_BIND_CODE: prdata = {16'd0, cfg_q.bind_code};
			REG_MAPPED_CODE: prdata = {16'd0, cfg_q.mapped_code};
			REG_CHANGED_CODE: prdata = {16'd0, cfg_q.changed_code};
			REG_IPV4_CODE: prdata = {24'd0, cfg_q.ipv4_code};
			default: prdata = '0;
		endcase
	end

endmodule

[hw/rtl/stun_binding_response_parser.sv]
// STUN binding response parser.
// Input channel: one datagram byte per word (data_byte, last_byte), handshake
// in_valid / in_stall. Output channel: one result word per datagram, carried
// on status, message_type and the mapped / changed address fields, handshake
// out_valid / out_stall.
// Each accepted byte updates the parse state in the cycle it is taken; the
// byte marked last_byte loads the result register, so the result shows on
// out_valid in the cycle after its last byte is accepted. One byte per cycle
// is sustained while in_stall stays low; the parse state and the result
// register are the only stages. While a result waits under out_stall, bytes
// without last_byte are still taken; in_stall rises only for a last byte
// that would need the occupied result register.
// Reset returns the parse state to the start of a header, empties the result
// register and loads the default codes into the configuration registers
// (APB port, registers at byte offsets 0, 4, 8, 12, pready always high).
// After each last byte the parser starts over on a fresh datagram.
module stun_binding_response_parser
	import stunbr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [15:0]       message_type,
	output logic              mapped_valid,
	output logic [31:0]       mapped_addr,
	output logic [15:0]       mapped_udp_port,
	output logic              changed_valid,
	output logic [31:0]       changed_addr,
	output logic [15:0]       changed_udp_port
);

	cfg_t cfg;

	stunbr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	assign pready = 1'b1;

	// parse state
	logic [2:0]       phase_q, n_phase;
	logic [OFS_W-1:0] ofs_q, n_ofs;
	logic [15:0]      htype_q, n_htype;
	logic [15:0]      rem_q, n_rem;
	logic [15:0]      atype_q, n_atype;
	logic [15:0]      alen_q, n_alen;
	logic [1:0]       pad_q, n_pad;
	logic [2:0]       err_q, n_err;
	logic [IDX_W-1:0] idx_q, n_idx;
	logic [1:0]       slot_q, n_slot;
	logic [1:0]       flag_q, n_flag;
	logic [15:0]      port_q [2];
	logic [15:0]      n_port [2];
	logic [31:0]      ip_q [2];
	logic [31:0]      n_ip [2];

	logic        do_start;
	logic [1:0]  pad_v;
	logic [1:0]  slot_v;
	logic        sidx;
	logic [IDX_W-1:0] idx_inc;

	// result register
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] mtype_q;
	logic [1:0]  rflag_q;
	logic [15:0] rport_q [2];
	logic [31:0] rip_q [2];
	logic [2:0]  res_status;

	logic in_acc, out_acc;

	assign out_acc = out_valid_q && !out_stall;
	assign in_stall = last_byte && out_valid_q && out_stall;
	assign in_acc = in_valid && !in_stall;

	assign sidx = (slot_q == SLOT_CHANGED);
	assign idx_inc = idx_q + IDX_W'(1);

	always_comb begin
		n_phase = phase_q;
		n_ofs = ofs_q;
		n_htype = htype_q;
		n_rem = rem_q;
		n_atype = atype_q;
		n_alen = alen_q;
		n_pad = pad_q;
		n_err = err_q;
		n_idx = idx_q;
		n_slot = slot_q;
		n_flag = flag_q;
		n_port = port_q;
		n_ip = ip_q;
		do_start = 1'b0;
		pad_v = '0;
		slot_v = SLOT_NONE;
		if (ofs_q < OFS_W'(MAX_PACKET_BYTES)) begin
			n_ofs = ofs_q + OFS_W'(1);
			unique case (phase_q)
				PH_HEADER: begin
					if (ofs_q < OFS_W'(2)) begin
						n_htype = {htype_q[7:0], data_byte};
						if (ofs_q == OFS_W'(1) && n_htype != cfg.bind_code) begin
							n_err = ST_NOT_BINDING;
							n_phase = PH_HALT;
						end
					end else if (ofs_q < OFS_W'(4)) begin
						n_rem = {rem_q[7:0], data_byte};
					end
					if (ofs_q == OFS_W'(HEADER_BYTES - 1))
						do_start = 1'b1;
				end
				PH_ATTR_HDR: begin
					n_rem = rem_q - 16'd1;
					if (idx_q < IDX_W'(2))
						n_atype = {atype_q[7:0], data_byte};
					else
						n_alen = {alen_q[7:0], data_byte};
					n_idx = idx_inc;
					if (idx_q == IDX_W'(3)) begin
						pad_v = 2'd0 - n_alen[1:0];
						n_pad = pad_v;
						if ({1'b0, n_alen} + {15'd0, pad_v} > {1'b0, n_rem}) begin
							n_err = ST_OVERRUN;
							n_phase = PH_HALT;
						end else begin
							// equal codes: mapped wins
							if (n_atype == cfg.mapped_code)
								slot_v = SLOT_MAPPED;
							else if (n_atype == cfg.changed_code)
								slot_v = SLOT_CHANGED;
							n_slot = slot_v;
							if (slot_v != SLOT_NONE && n_alen != ADDR_LEN_SHORT
									&& n_alen != ADDR_LEN_LONG) begin
								n_err = ST_BAD_ADDR;
								n_phase = PH_HALT;
							end else begin
								if (slot_v == SLOT_MAPPED)
									n_flag[0] = 1'b0;
								else if (slot_v == SLOT_CHANGED)
									n_flag[1] = 1'b0;
								n_idx = '0;
								if (n_alen == 16'd0) begin
									if (pad_v != 2'd0)
										n_phase = PH_PAD;
									else
										do_start = 1'b1;
								end else begin
									n_phase = PH_VALUE;
								end
							end
						end
					end
				end
				PH_VALUE: begin
					n_rem = rem_q - 16'd1;
					n_idx = idx_inc;
					if (slot_q != SLOT_NONE) begin
						if (idx_q == IDX_W'(1)) begin
							if (data_byte != cfg.ipv4_code) begin
								n_err = ST_BAD_ADDR;
								n_phase = PH_HALT;
							end
						end else if (idx_q == IDX_W'(2)) begin
							n_port[sidx][15:8] = data_byte;
						end else if (idx_q == IDX_W'(3)) begin
							n_port[sidx][7:0] = data_byte;
						end else if (idx_q > IDX_W'(3) && idx_q < IDX_W'(8)) begin
							n_ip[sidx] = {ip_q[sidx][23:0], data_byte};
							if (idx_q == IDX_W'(7))
								n_flag[sidx] = 1'b1;
						end
					end
					if (n_phase != PH_HALT && {{(16-IDX_W){1'b0}}, idx_inc} >= alen_q) begin
						if (pad_q != 2'd0)
							n_phase = PH_PAD;
						else
							do_start = 1'b1;
					end
				end
				PH_PAD: begin
					n_rem = rem_q - 16'd1;
					n_pad = pad_q - 2'd1;
					if (n_pad == 2'd0)
						do_start = 1'b1;
				end
				default: ;
			endcase
			if (do_start) begin
				if (n_rem == 16'd0) begin
					n_phase = PH_DONE;
				end else if (n_rem < 16'd4) begin
					n_err = ST_OVERRUN;
					n_phase = PH_HALT;
				end else begin
					n_phase = PH_ATTR_HDR;
					n_idx = '0;
					n_atype = '0;
					n_alen = '0;
					n_slot = SLOT_NONE;
				end
			end
		end
	end

	always_comb begin
		if (n_err != ST_OK)
			res_status = n_err;
		else if (n_phase == PH_DONE)
			res_status = ST_OK;
		else
			res_status = ST_TRUNCATED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			ofs_q <= '0;
			htype_q <= '0;
			rem_q <= '0;
			atype_q <= '0;
			alen_q <= '0;
			pad_q <= '0;
			err_q <= ST_OK;
			idx_q <= '0;
			slot_q <= SLOT_NONE;
			flag_q <= '0;
		end else if (in_acc) begin
			if (last_byte) begin
				phase_q <= PH_HEADER;
				ofs_q <= '0;
				htype_q <= '0;
				rem_q <= '0;
				atype_q <= '0;
				alen_q <= '0;
				pad_q <= '0;
				err_q <= ST_OK;
				idx_q <= '0;
				slot_q <= SLOT_NONE;
				flag_q <= '0;
			end else begin
				phase_q <= n_phase;
				ofs_q <= n_ofs;
				htype_q <= n_htype;
				rem_q <= n_rem;
				atype_q <= n_atype;
				alen_q <= n_alen;
				pad_q <= n_pad;
				err_q <= n_err;
				idx_q <= n_idx;
				slot_q <= n_slot;
				flag_q <= n_flag;
			end
		end
	end

	// address bytes are only read once their valid flag is set
	always_ff @(posedge clk) begin
		if (in_acc) begin
			port_q <= n_port;
			ip_q <= n_ip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_acc && last_byte)
			out_valid_q <= 1'b1;
		else if (out_acc)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc && last_byte) begin
			status_q <= res_status;
			mtype_q <= n_htype;
			rflag_q <= n_flag;
			rport_q[0] <= n_flag[0] ? n_port[0] : 16'd0;
			rport_q[1] <= n_flag[1] ? n_port[1] : 16'd0;
			rip_q[0] <= n_flag[0] ? n_ip[0] : 32'd0;
			rip_q[1] <= n_flag[1] ? n_ip[1] : 32'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign message_type = mtype_q;
	assign mapped_valid = rflag_q[0];
	assign mapped_addr = rip_q[0];
	assign mapped_udp_port = rport_q[0];
	assign changed_valid = rflag_q[1];
	assign changed_addr = rip_q[1];
	assign changed_udp_port = rport_q[1];

endmodule

[hw/rtl/stunbr_checker.sv]
module stunbr_checker
	import stunbr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              last_byte,
	input logic              out_valid,
	input logic              out_stall,
	input logic [2:0]        status,
	input logic [15:0]       message_type,
	input logic              mapped_valid,
	input logic [31:0]       mapped_addr,
	input logic [15:0]       mapped_udp_port,
	input logic              changed_valid,
	input logic [31:0]       changed_addr,
	input logic [15:0]       changed_udp_port
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(message_type))
		else $error("result word changed under stall");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte |=> out_valid)
		else $error("last byte accepted without a result");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_TRUNCATED)
		else $error("status code out of range");

	a_mapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mapped_valid |-> mapped_addr == 32'd0 && mapped_udp_port == 16'd0)
		else $error("mapped address not cleared");

	a_changed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !changed_valid |-> changed_addr == 32'd0 && changed_udp_port == 16'd0)
		else $error("changed address not cleared");

endmodule

bind stun_binding_response_parser stunbr_checker u_stunbr_checker (.*);

[tb/sv/stunbr_tb_pkg.sv]
package stunbr_tb_pkg;
	import stunbr_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] message_type;
		logic        mapped_valid;
		logic [31:0] mapped_addr;
		logic [15:0] mapped_udp_port;
		logic        changed_valid;
		logic [31:0] changed_addr;
		logic [15:0] changed_udp_port;
	} response_t;

	class response_scoreboard;
		logic [15:0] bind_code, mapped_code, changed_code;
		logic [7:0]  ipv4_code;
		response_t   expected_q[$];
		int unsigned mismatches;
		int unsigned responses_seen;

		// parser shadow state
		logic [2:0]  phase;
		int unsigned offset;
		int unsigned attr_pos;
		logic [15:0] hdr_type, rem_len, attr_type, attr_len;
		logic [1:0]  pad_cnt;
		logic [1:0]  slot;
		logic [2:0]  err;
		logic [7:0]  family;
		logic [47:0] addr [2];
		bit          addr_ok [2];

		function new();
			bind_code = RST_BIND_CODE;
			mapped_code = RST_MAPPED_CODE;
			changed_code = RST_CHANGED_CODE;
			ipv4_code = RST_IPV4_CODE;
			mismatches = 0;
			responses_seen = 0;
			restart();
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_BIND_CODE: bind_code = val[15:0];
				REG_MAPPED_CODE: mapped_code = val[15:0];
				REG_CHANGED_CODE: changed_code = val[15:0];
				REG_IPV4_CODE: ipv4_code = val[7:0];
				default: ;
			endcase
		endfunction

		function void restart();
			phase = PH_HEADER;
			offset = 0;
			attr_pos = 0;
			hdr_type = '0;
			rem_len = '0;
			attr_type = '0;
			attr_len = '0;
			pad_cnt = '0;
			slot = SLOT_NONE;
			err = ST_OK;
			family = '0;
			addr[0] = '0;
			addr[1] = '0;
			addr_ok[0] = 1'b0;
			addr_ok[1] = 1'b0;
		endfunction

		function void halt(logic [2:0] code);
			err = code;
			phase = PH_HALT;
		endfunction

		function void next_attr();
			if (rem_len == 0) begin
				phase = PH_DONE;
			end else if (rem_len < 4) begin
				halt(ST_OVERRUN);
			end else begin
				phase = PH_ATTR_HDR;
				attr_pos = 0;
				attr_type = '0;
				attr_len = '0;
				slot = SLOT_NONE;
			end
		endfunction

		function void close_value();
			if (pad_cnt != 0)
				phase = PH_PAD;
			else
				next_attr();
		endfunction

		function void attr_header_done();
			pad_cnt = ~attr_len[1:0] + 2'd1;
			if ({1'b0, attr_len} + 17'(pad_cnt) > {1'b0, rem_len}) begin
				halt(ST_OVERRUN);
				return;
			end
			// mapped takes priority when both codes match
			if (attr_type == mapped_code)
				slot = SLOT_MAPPED;
			else if (attr_type == changed_code)
				slot = SLOT_CHANGED;
			else
				slot = SLOT_NONE;
			if (slot != SLOT_NONE) begin
				if (attr_len != ADDR_LEN_SHORT && attr_len != ADDR_LEN_LONG) begin
					halt(ST_BAD_ADDR);
					return;
				end
				addr_ok[(slot == SLOT_MAPPED) ? 0 : 1] = 1'b0;
			end
			attr_pos = 0;
			if (attr_len == 0)
				close_value();
			else
				phase = PH_VALUE;
		endfunction

		function void take(logic [7:0] b);
			int s;
			case (phase)
				PH_HEADER: begin
					if (offset < 2) begin
						hdr_type = {hdr_type[7:0], b};
						if (offset == 1 && hdr_type != bind_code) begin
							halt(ST_NOT_BINDING);
							return;
						end
					end else if (offset < 4) begin
						rem_len = {rem_len[7:0], b};
					end
					if (offset == HEADER_BYTES - 1)
						next_attr();
				end
				PH_ATTR_HDR: begin
					rem_len = rem_len - 16'd1;
					if (attr_pos < 2)
						attr_type = {attr_type[7:0], b};
					else
						attr_len = {attr_len[7:0], b};
					attr_pos++;
					if (attr_pos == 4)
						attr_header_done();
				end
				PH_VALUE: begin
					rem_len = rem_len - 16'd1;
					if (slot != SLOT_NONE) begin
						s = (slot == SLOT_MAPPED) ? 0 : 1;
						// value: skip, family, port (2), ip (4), rest skipped
						if (attr_pos == 1) begin
							family = b;
							if (b != ipv4_code) begin
								halt(ST_BAD_ADDR);
								return;
							end
						end else if (attr_pos == 2) begin
							addr[s] = {40'd0, b};
						end else if (attr_pos > 2 && attr_pos < 8) begin
							addr[s] = {addr[s][39:0], b};
							if (attr_pos == 7)
								addr_ok[s] = 1'b1;
						end
					end
					attr_pos++;
					if (attr_pos >= attr_len)
						close_value();
				end
				PH_PAD: begin
					rem_len = rem_len - 16'd1;
					pad_cnt = pad_cnt - 2'd1;
					if (pad_cnt == 0)
						next_attr();
				end
				default: ;
			endcase
		endfunction

		function void accept_byte(logic [7:0] b, logic last);
			response_t want;
			if (offset < MAX_PACKET_BYTES) begin
				take(b);
				offset++;
			end
			if (!last)
				return;
			if (err != ST_OK)
				want.status = err;
			else if (phase == PH_DONE)
				want.status = ST_OK;
			else
				want.status = ST_TRUNCATED;
			want.message_type = hdr_type;
			want.mapped_valid = addr_ok[0];
			want.mapped_addr = addr_ok[0] ? addr[0][31:0] : 32'd0;
			want.mapped_udp_port = addr_ok[0] ? addr[0][47:32] : 16'd0;
			want.changed_valid = addr_ok[1];
			want.changed_addr = addr_ok[1] ? addr[1][31:0] : 32'd0;
			want.changed_udp_port = addr_ok[1] ? addr[1][47:32] : 16'd0;
			expected_q.push_back(want);
			restart();
		endfunction

		function string fmt(response_t r);
			return $sformatf("st=%0d type=%h map=%b %h:%h chg=%b %h:%h", r.status,
				r.message_type, r.mapped_valid, r.mapped_addr, r.mapped_udp_port,
				r.changed_valid, r.changed_addr, r.changed_udp_port);
		endfunction

		function void check_response(response_t got);
			response_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: response with none pending: %s", $time, fmt(got));
				return;
			end
			want = expected_q.pop_front();
			responses_seen++;
			if (got.status !== want.status || got.message_type !== want.message_type ||
					got.mapped_valid !== want.mapped_valid ||
					got.mapped_addr !== want.mapped_addr ||
					got.mapped_udp_port !== want.mapped_udp_port ||
					got.changed_valid !== want.changed_valid ||
					got.changed_addr !== want.changed_addr ||
					got.changed_udp_port !== want.changed_udp_port) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: response %0d expected %s", $time, responses_seen, fmt(want));
					$display("%0t: response %0d actual   %s", $time, responses_seen, fmt(got));
				end
			end
		endfunction
	endclass

endpackage

[tb/sv/tb_top.sv]
module tb_top;
	import stunbr_pkg::*;
	import stunbr_tb_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        data_byte;
	logic              last_byte;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        status;
	logic [15:0]       message_type;
	logic              mapped_valid;
	logic [31:0]       mapped_addr;
	logic [15:0]       mapped_udp_port;
	logic              changed_valid;
	logic [31:0]       changed_addr;
	logic [15:0]       changed_udp_port;

	response_scoreboard sb;
	response_t          seen_word;
	logic [7:0]         body[$];
	bit                 quiet;
	bit                 hold_off_req;
	int                 bytes_fed;

	stun_binding_response_parser u_top (.*);

	assign seen_word = {status, message_type, mapped_valid, mapped_addr, mapped_udp_port,
		changed_valid, changed_addr, changed_udp_port};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.accept_byte(data_byte, last_byte);
		if (arst_n && out_valid && !out_stall)
			sb.check_response(seen_word);
	end

	// receiver: random stall, or one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (500) @(posedge clk);
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < 35);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				idle = 0;
			end else begin
				idle = idle + 1;
				if (idle >= 3000) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	function automatic void put_be16(input logic [15:0] v);
		body.push_back(v[15:8]);
		body.push_back(v[7:0]);
	endfunction

	function automatic void put_random(input int n);
		repeat (n) body.push_back(8'($urandom));
	endfunction

	function automatic void add_address(input logic [15:0] code, input logic [15:0] len,
			input logic [7:0] fam, input logic [15:0] port, input logic [31:0] ip);
		put_be16(code);
		put_be16(len);
		put_random(1);
		body.push_back(fam);
		put_be16(port);
		put_be16(ip[31:16]);
		put_be16(ip[15:0]);
		put_random(int'(len) - 8);
	endfunction

	// attribute with random value, padded to a multiple of 4 bytes
	function automatic void add_opaque(input logic [15:0] code, input logic [15:0] len);
		put_be16(code);
		put_be16(len);
		put_random(int'(len));
		put_random((4 - int'(len[1:0])) % 4);
	endfunction

	function automatic logic [15:0] other_code();
		logic [15:0] c;
		do
			c = 16'($urandom);
		while (c == sb.mapped_code || c == sb.changed_code);
		return c;
	endfunction

	task automatic send_byte(input logic [7:0] d, input bit l);
		while (!quiet && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// header + body; len_field < 0 takes the body size, keep > 0 cuts the datagram,
	// extra appends bytes past the message
	task automatic send_datagram(input logic [15:0] mtype, input int len_field,
			input int keep, input int extra);
		logic [7:0]  pkt[$];
		logic [15:0] mlen;
		mlen = (len_field < 0) ? 16'(body.size()) : 16'(len_field);
		pkt.push_back(mtype[15:8]);
		pkt.push_back(mtype[7:0]);
		pkt.push_back(mlen[15:8]);
		pkt.push_back(mlen[7:0]);
		repeat (16) pkt.push_back(8'($urandom));
		foreach (body[i]) pkt.push_back(body[i]);
		body.delete();
		if (keep > 0)
			while (pkt.size() > keep) void'(pkt.pop_back());
		bytes_fed += pkt.size();
		repeat (extra) pkt.push_back(8'($urandom));
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	task automatic random_datagram();
		int n_attr, pick, flaw, keep, extra, len_field, bad_len, d;
		logic [15:0] mtype;
		logic [7:0]  fam;
		n_attr = $urandom_range(0, 4);
		repeat (n_attr) begin
			pick = $urandom_range(0, 19);
			fam = ($urandom_range(0, 29) == 0) ? 8'($urandom) : sb.ipv4_code;
			bad_len = $urandom_range(0, 24);
			if (bad_len == 8 || bad_len == 20)
				bad_len++;
			if (pick < 7)
				add_address(sb.mapped_code, $urandom_range(0, 1) ? 16'd20 : 16'd8, fam,
					16'($urandom), $urandom);
			else if (pick < 14)
				add_address(sb.changed_code, $urandom_range(0, 1) ? 16'd20 : 16'd8, fam,
					16'($urandom), $urandom);
			else if (pick < 19)
				add_opaque(other_code(), 16'($urandom_range(0, 11)));
			else
				add_opaque($urandom_range(0, 1) ? sb.mapped_code : sb.changed_code,
					16'(bad_len));
		end
		mtype = sb.bind_code;
		len_field = -1;
		keep = 0;
		extra = 0;
		flaw = $urandom_range(0, 99);
		if (flaw < 62) begin
			if ($urandom_range(0, 4) == 0)
				extra = $urandom_range(1, 6);
		end else if (flaw < 70) begin
			mtype = 16'($urandom);
		end else if (flaw < 78) begin
			d = $urandom_range(0, 6);
			len_field = body.size() + d - 3;
			if (len_field < 0)
				len_field = 0;
		end else if (flaw < 90) begin
			keep = $urandom_range(1, 19 + body.size());
		end else begin
			body.delete();
			put_random($urandom_range(0, 24));
			mtype = $urandom_range(0, 1) ? sb.bind_code : 16'($urandom);
			len_field = $urandom_range(0, 40);
		end
		send_datagram(mtype, len_field, keep, extra);
	endtask

	task automatic random_phase(input int target);
		int fed0;
		fed0 = bytes_fed;
		while (bytes_fed - fed0 < target)
			random_datagram();
	endtask

	// sender stops until every pending response is out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic reconfigure(input logic [31:0] b, m, c, f);
		drain();
		apb_write(REG_BIND_CODE, b);
		apb_write(REG_MAPPED_CODE, m);
		apb_write(REG_CHANGED_CODE, c);
		apb_write(REG_IPV4_CODE, f);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		quiet = 1'b0;
		hold_off_req = 1'b0;
		bytes_fed = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases under the reset codes
		send_datagram(sb.bind_code, -1, 0, 0);
		add_address(sb.mapped_code, 16'd8, sb.ipv4_code, 16'hFFFF, 32'hFFFF_FFFF);
		add_address(sb.changed_code, 16'd20, sb.ipv4_code, 16'h0000, 32'h0000_0000);
		send_datagram(sb.bind_code, -1, 0, 0);
		send_datagram(16'h0000, -1, 2, 0);
		send_datagram(16'hFFFF, -1, 0, 0);
		send_datagram(sb.bind_code, -1, 1, 0);
		// fewer than 4 bytes left where an attribute header starts
		send_datagram(sb.bind_code, 3, 0, 0);
		add_opaque(other_code(), 16'd4);
		send_datagram(sb.bind_code, body.size() + 2, 0, 0);
		// attribute length beyond the message
		put_be16(other_code());
		put_be16(16'd100);
		put_random(8);
		send_datagram(sb.bind_code, -1, 0, 0);
		add_opaque(sb.mapped_code, 16'd12);
		send_datagram(sb.bind_code, -1, 0, 0);
		add_opaque(sb.changed_code, 16'd0);
		send_datagram(sb.bind_code, -1, 0, 0);
		add_address(sb.changed_code, 16'd8, ~sb.ipv4_code, 16'($urandom), $urandom);
		send_datagram(sb.bind_code, -1, 0, 0);
		// second mapped address replaces the first
		add_address(sb.mapped_code, 16'd8, sb.ipv4_code, 16'($urandom), $urandom);
		add_address(sb.mapped_code, 16'd20, sb.ipv4_code, 16'($urandom), $urandom);
		send_datagram(sb.bind_code, -1, 0, 0);
		// good changed address survives a later bad mapped one
		add_address(sb.changed_code, 16'd8, sb.ipv4_code, 16'($urandom), $urandom);
		add_address(sb.mapped_code, 16'd20, ~sb.ipv4_code, 16'($urandom), $urandom);
		send_datagram(sb.bind_code, -1, 0, 0);
		for (int len = 0; len < 4; len++)
			add_opaque(other_code(), 16'(len));
		add_address(sb.mapped_code, 16'd8, sb.ipv4_code, 16'($urandom), $urandom);
		send_datagram(sb.bind_code, -1, 0, 0);
		add_address(sb.mapped_code, 16'd20, sb.ipv4_code, 16'($urandom), $urandom);
		send_datagram(sb.bind_code, -1, 26, 0);
		add_address(sb.changed_code, 16'd8, sb.ipv4_code, 16'($urandom), $urandom);
		send_datagram(sb.bind_code, -1, 0, 5);
		// runs past the packet byte limit, sent with no idle cycles
		quiet = 1'b1;
		add_opaque(other_code(), 16'd492);
		send_datagram(sb.bind_code, -1, 0, 0);
		quiet = 1'b0;
		send_datagram(sb.bind_code, 16'hFFFF, 0, 0);

		random_phase(60);

		reconfigure(32'h0000_FFFF, 32'h0000_0000, 32'h0000_FFFF, 32'h0000_00FF);
		// receiver holds off while two datagrams come in
		hold_off_req = 1'b1;
		repeat (2) random_datagram();

		// mapped and changed share one code
		reconfigure(32'h0000_0000, 32'h0000_1234, 32'h0000_1234, 32'h0000_0000);
		add_address(sb.mapped_code, 16'd8, sb.ipv4_code, 16'($urandom), $urandom);
		add_address(sb.changed_code, 16'd20, sb.ipv4_code, 16'($urandom), $urandom);
		send_datagram(sb.bind_code, -1, 0, 0);
		random_phase(50);

		reconfigure($urandom, $urandom, $urandom, $urandom);
		random_phase(50);

		drain();
		repeat (5) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/stunbr_pkg.sv
hw/rtl/stunbr_cfg.sv
hw/rtl/stun_binding_response_parser.sv
hw/rtl/stunbr_checker.sv
tb/sv/stunbr_tb_pkg.sv
tb/sv/tb_top.sv
